// ===== hdl/arh_pkg.sv =====
// Package with shared types, constants and sizes of the auto-ranging histogram.
package arh_pkg;

  localparam int MaxSamples = 4096;
  localparam int NumBins    = 256;
  localparam int AddrW      = $clog2(MaxSamples);
  localparam int CntW       = $clog2(MaxSamples + 1);
  localparam int BinW       = 13;
  localparam int BinAw      = 8;
  localparam logic [BinW-1:0] CountMax = 13'd8191;
  localparam logic [8:0] ScaleTop = 9'd254;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_READ = 2'd1,
    CMD_MAP  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_BUILT = 2'd0,
    KIND_READ  = 2'd1,
    KIND_MAP   = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_RANGE,
    ST_CLEAR,
    ST_BIN_RD,
    ST_BIN_DIV,
    ST_BIN_WR,
    ST_PEAK,
    ST_READ,
    ST_READ_DIV,
    ST_MAP_DIV,
    ST_OUT
  } state_t;

  // Request to and answer from the shared divider.
  typedef struct packed {
    logic        start;
    logic [40:0] num;
    logic [32:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [40:0] quo;
  } div_rsp_t;

endpackage

// ===== hdl/arh_div.sv =====
// Restoring divider, one quotient bit per cycle, for the bin scale and fractions.
module arh_div (
  input  logic              clk,
  input  logic              rst_n,
  input  arh_pkg::div_req_t req,
  output arh_pkg::div_rsp_t rsp
);

  logic [40:0] quo_r, quo_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [32:0] den_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [33:0] trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[32:0], quo_r[40]};
    if (req.start) begin
      quo_nxt  = req.num;
      rem_nxt  = '0;
      cnt_nxt  = 6'd41;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt = {quo_r[39:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[39:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (req.start) den_r <= req.den;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

  a_done_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("divider done held");
  a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !req.start && cnt_r == 6'd1) |=> done_r) else $error("divider lost done");
  a_idle_no_done: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy_r && !req.start) |=> !done_r) else $error("spurious divider done");

endmodule

// ===== hdl/auto_range_histogram.sv =====
// Top level of the auto-ranging 256-bin histogram: stores, sequencer and result register.
//
//  channel | direction | ports
//  in_     | input     | in_valid, in_stall, in_cmd, in_sample_value, in_is_missing,
//          |           | in_is_last, in_bin_index
//  out_    | output    | out_valid, out_stall, out_result_kind, out_bin_count, ...
//
// A bin read or a map runs one 41-step division when it divides and none when no
// division is needed.
// A build walks the sample store twice and the bin store twice, and runs a division
// for each valid sample that does not go straight to bin 1; missing samples skip it.
// Reset clears the control state and then sweeps all 256 entries of the bin store to zero.
// A new word is taken only when the block is idle and the result register is free.
module auto_range_histogram (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic signed [31:0] in_sample_value,
  input  logic        in_is_missing,
  input  logic        in_is_last,
  input  logic [7:0]  in_bin_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [12:0] out_bin_count,
  output logic [15:0] out_bin_fraction,
  output logic [7:0]  out_display_byte,
  output logic [12:0] out_peak_count,
  output logic signed [31:0] out_range_min,
  output logic signed [31:0] out_range_max
);

  localparam int AW = arh_pkg::AddrW;
  localparam int CW = arh_pkg::CntW;

  // Sample store: value and missing flag.
  logic [32:0] smem [arh_pkg::MaxSamples];
  logic [32:0] srd_r;
  logic        swe;
  logic [AW-1:0] swa, sra;
  logic [32:0] swd;

  // Bin store.
  logic [12:0] bmem [arh_pkg::NumBins];
  logic [12:0] brd_r;
  logic        bwe;
  logic [7:0]  bwa, bra;
  logic [12:0] bwd;

  always_ff @(posedge clk) begin
    if (swe) smem[swa] <= swd;
    srd_r <= smem[sra];
  end
  always_ff @(posedge clk) begin
    if (bwe) bmem[bwa] <= bwd;
    brd_r <= bmem[bra];
  end

  arh_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW:0]   ptr_r, ptr_nxt;
  logic signed [31:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic          any_r, any_nxt;
  logic [12:0]   peak_r, peak_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic [1:0]    kind_r, kind_nxt;
  logic [12:0]   ocnt_r, ocnt_nxt;
  logic [15:0]   ofrac_r, ofrac_nxt;
  logic [7:0]    obyte_r, obyte_nxt;
  logic          ovalid_r, ovalid_nxt;
  logic [7:0]    bsel_r, bsel_nxt;

  arh_pkg::div_req_t dreq;
  arh_pkg::div_rsp_t drsp;

  arh_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic accept;
  logic signed [31:0] cur_val;
  logic [32:0] diff, span;
  logic        direct1;
  logic [7:0]  qbyte;
  logic [AW-1:0] ptr_a;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != arh_pkg::ST_IDLE) || ovalid_r;
  assign ptr_a    = ptr_r[AW-1:0];

  always_comb begin
    // During binning the sample comes straight from the store's read port.
    cur_val = (state_r == arh_pkg::ST_BIN_DIV) ? $signed(srd_r[31:0]) : val_r;
    diff = {cur_val[31], cur_val} - {lo_r[31], lo_r};
    span = {hi_r[31], hi_r} - {lo_r[31], lo_r};
    direct1 = (hi_r <= lo_r) || (cur_val <= lo_r);
    qbyte = (drsp.quo >= 41'd254) ? 8'd255 : (drsp.quo[7:0] + 8'd1);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      arh_pkg::ST_INIT: if (ptr_r[7:0] == 8'd255) state_nxt = arh_pkg::ST_IDLE;
      arh_pkg::ST_IDLE: begin
        if (accept) begin
          priority case (arh_pkg::cmd_t'(in_cmd))
            arh_pkg::CMD_LOAD: state_nxt = in_is_last ? arh_pkg::ST_RANGE : arh_pkg::ST_IDLE;
            arh_pkg::CMD_READ: state_nxt = arh_pkg::ST_READ;
            arh_pkg::CMD_MAP:
              state_nxt = in_is_missing ? arh_pkg::ST_OUT : arh_pkg::ST_MAP_DIV;
            default: state_nxt = arh_pkg::ST_IDLE;
          endcase
        end
      end
      arh_pkg::ST_RANGE: if (ptr_r == {1'b0, count_r}) state_nxt = arh_pkg::ST_CLEAR;
      arh_pkg::ST_CLEAR: if (ptr_r[7:0] == 8'd255) state_nxt = arh_pkg::ST_BIN_RD;
      arh_pkg::ST_BIN_RD: begin
        if (ptr_r == {1'b0, count_r}) state_nxt = arh_pkg::ST_PEAK;
        else state_nxt = arh_pkg::ST_BIN_DIV;
      end
      arh_pkg::ST_BIN_DIV: begin
        if (srd_r[32]) state_nxt = arh_pkg::ST_BIN_RD;
        else if (direct1 || drsp.done) state_nxt = arh_pkg::ST_BIN_WR;
      end
      arh_pkg::ST_BIN_WR: state_nxt = arh_pkg::ST_BIN_RD;
      arh_pkg::ST_PEAK: if (ptr_r == 9'd257) state_nxt = arh_pkg::ST_OUT;
      arh_pkg::ST_READ: state_nxt = (peak_r == '0) ? arh_pkg::ST_OUT : arh_pkg::ST_READ_DIV;
      arh_pkg::ST_READ_DIV: if (drsp.done) state_nxt = arh_pkg::ST_OUT;
      arh_pkg::ST_MAP_DIV: if (direct1 || drsp.done) state_nxt = arh_pkg::ST_OUT;
      arh_pkg::ST_OUT: state_nxt = arh_pkg::ST_IDLE;
      default: state_nxt = arh_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    count_nxt = count_r; ptr_nxt = ptr_r; lo_nxt = lo_r; hi_nxt = hi_r;
    any_nxt = any_r; peak_nxt = peak_r; val_nxt = val_r;
    kind_nxt = kind_r; ocnt_nxt = ocnt_r;
    ofrac_nxt = ofrac_r; obyte_nxt = obyte_r; ovalid_nxt = ovalid_r;
    bsel_nxt = bsel_r;
    swe = 1'b0; swa = count_r[AW-1:0]; swd = {in_is_missing, in_sample_value};
    sra = ptr_a;
    bwe = 1'b0; bwa = bsel_r; bwd = '0; bra = ptr_r[7:0];
    dreq = '0;
    if (ovalid_r && !out_stall) ovalid_nxt = 1'b0;
    unique case (state_r)
      arh_pkg::ST_INIT: begin
        bwe = 1'b1; bwa = ptr_r[7:0]; bwd = '0;
        ptr_nxt = ptr_r + 1'b1;
        if (state_nxt == arh_pkg::ST_IDLE) ptr_nxt = '0;
      end
      arh_pkg::ST_IDLE: begin
        if (accept) begin
          val_nxt = in_sample_value;
          ptr_nxt = '0; any_nxt = 1'b0; ocnt_nxt = '0; ofrac_nxt = '0; obyte_nxt = '0;
          bra = in_bin_index;
          kind_nxt = in_cmd;
          if (in_cmd == arh_pkg::CMD_LOAD) begin
            if (count_r < CW'(arh_pkg::MaxSamples)) begin
              swe = 1'b1;
              count_nxt = count_r + 1'b1;
            end
            lo_nxt = in_is_last ? '0 : lo_r;
            hi_nxt = in_is_last ? '0 : hi_r;
          end
        end
      end
      arh_pkg::ST_RANGE: begin
        // Read is issued at ptr; data for ptr-1 lands now.
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r != '0 && !srd_r[32]) begin
          any_nxt = 1'b1;
          if (!any_r || $signed(srd_r[31:0]) < lo_r) lo_nxt = srd_r[31:0];
          if (!any_r || $signed(srd_r[31:0]) > hi_r) hi_nxt = srd_r[31:0];
        end
        if (state_nxt == arh_pkg::ST_CLEAR) ptr_nxt = '0;
      end
      arh_pkg::ST_CLEAR: begin
        bwe = 1'b1; bwa = ptr_r[7:0]; bwd = '0;
        ptr_nxt = ptr_r + 1'b1;
        if (state_nxt == arh_pkg::ST_BIN_RD) ptr_nxt = '0;
      end
      arh_pkg::ST_BIN_RD: begin
        sra = ptr_a;
        ptr_nxt = ptr_r + 1'b1;
        if (state_nxt == arh_pkg::ST_PEAK) begin ptr_nxt = '0; peak_nxt = '0; end
      end
      arh_pkg::ST_BIN_DIV: begin
        // Keep reading the same entry so the sample stays on the read port.
        sra = ptr_a - 1'b1;
        if (!srd_r[32]) begin
          if (direct1) begin
            bsel_nxt = 8'd1; bra = 8'd1;
          end else if (drsp.done) begin
            bsel_nxt = qbyte; bra = qbyte;
          end else if (!any_r) begin
            dreq.start = 1'b1;
            dreq.num = 41'({8'd0, diff}) * 41'(arh_pkg::ScaleTop);
            dreq.den = span;
          end
        end
      end
      arh_pkg::ST_BIN_WR: begin
        bwe = 1'b1;
        bwd = (brd_r < arh_pkg::CountMax) ? brd_r + 13'd1 : brd_r;
      end
      arh_pkg::ST_PEAK: begin
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r != '0 && brd_r > peak_r) peak_nxt = brd_r;
        if (state_nxt == arh_pkg::ST_OUT) begin
          count_nxt = '0; kind_nxt = arh_pkg::KIND_BUILT;
        end
      end
      arh_pkg::ST_READ: begin
        ocnt_nxt = brd_r;
        if (peak_r != '0) begin
          dreq.start = 1'b1; dreq.num = {13'd0, brd_r, 15'd0};
          dreq.den = {20'd0, peak_r};
        end
      end
      arh_pkg::ST_READ_DIV: if (drsp.done) ofrac_nxt = drsp.quo[15:0];
      arh_pkg::ST_MAP_DIV: begin
        if (direct1) obyte_nxt = 8'd1;
        else if (drsp.done) obyte_nxt = qbyte;
        else if (!any_r) begin
          dreq.start = 1'b1; dreq.num = 41'({8'd0, diff}) * 41'(arh_pkg::ScaleTop);
          dreq.den = span;
        end
      end
      arh_pkg::ST_OUT: ovalid_nxt = 1'b1;
      default: ;
    endcase
    // any_r doubles as "division launched" in the divide states.
    if (dreq.start) any_nxt = 1'b1;
    if ((state_r == arh_pkg::ST_BIN_DIV && state_nxt != arh_pkg::ST_BIN_DIV) ||
        (state_r == arh_pkg::ST_MAP_DIV && state_nxt != arh_pkg::ST_MAP_DIV) ||
        (state_r == arh_pkg::ST_CLEAR)) any_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= arh_pkg::ST_INIT;
      count_r <= '0; lo_r <= '0; hi_r <= '0; peak_r <= '0;
      ovalid_r <= 1'b0; any_r <= 1'b0; ptr_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt; peak_r <= peak_nxt;
      ovalid_r <= ovalid_nxt; any_r <= any_nxt; ptr_r <= ptr_nxt;
    end
    val_r <= val_nxt;
    kind_r <= kind_nxt; ocnt_r <= ocnt_nxt; ofrac_r <= ofrac_nxt;
    obyte_r <= obyte_nxt; bsel_r <= bsel_nxt;
  end

  assign out_valid        = ovalid_r;
  assign out_result_kind  = kind_r;
  assign out_bin_count    = ocnt_r;
  assign out_bin_fraction = ofrac_r;
  assign out_display_byte = obyte_r;
  assign out_peak_count   = peak_r;
  assign out_range_min    = lo_r;
  assign out_range_max    = hi_r;

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != arh_pkg::ST_IDLE) |-> in_stall) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(arh_pkg::MaxSamples)) else $error("sample count overflow");
  a_build_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == arh_pkg::ST_PEAK && state_nxt == arh_pkg::ST_OUT) |=> count_r == '0)
    else $error("count not cleared after build");

endmodule

// ===== tb/tb_auto_range_histogram.sv =====
// Self-checking testbench of the auto-ranging histogram with a built-in predictor.
`timescale 1ns / 100ps

module tb_auto_range_histogram;

  localparam int CycleLimit = 4000000;

  typedef struct {
    logic [1:0]         kind;
    logic [12:0]        count;
    logic [15:0]        fraction;
    logic [7:0]         dbyte;
    logic [12:0]        peak;
    logic signed [31:0] rmin;
    logic signed [31:0] rmax;
  } hist_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_cmd = arh_pkg::CMD_NONE;
  logic signed [31:0] in_sample_value = '0;
  logic               in_is_missing = 1'b0;
  logic               in_is_last = 1'b0;
  logic [7:0]         in_bin_index = '0;
  logic               out_valid;
  logic               out_stall = 1'b1;
  logic [1:0]         out_result_kind;
  logic [12:0]        out_bin_count;
  logic [15:0]        out_bin_fraction;
  logic [7:0]         out_display_byte;
  logic [12:0]        out_peak_count;
  logic signed [31:0] out_range_min;
  logic signed [31:0] out_range_max;

  // Predicted histogram state.
  logic signed [31:0] sample_val [arh_pkg::MaxSamples];
  bit                 sample_miss [arh_pkg::MaxSamples];
  int                 num_loaded;
  longint             low_val, high_val;
  int                 bin_counts [arh_pkg::NumBins];
  int                 peak_val;

  hist_result_t       pending_results[$];
  int                 errors = 0;
  int                 cycles = 0;
  int                 send_gap_max = 12;
  int                 stall_max = 12;
  int                 stall_left = 0;
  int                 results_taken = 0;
  int                 results_seen = 0;
  int                 words_sent = 0;

  auto_range_histogram dut (.*);

  always #4 clk = ~clk;

  function automatic int scaled_bin(longint v);
    longint q;
    if (high_val <= low_val || v <= low_val) return 1;
    q = ((v - low_val) * 254) / (high_val - low_val) + 1;
    return (q > 255) ? 255 : int'(q);
  endfunction

  task automatic build_histogram();
    bit any_valid;
    int b;
    any_valid = 1'b0;
    low_val = 0;
    high_val = 0;
    for (int i = 0; i < num_loaded; i++) begin
      if (!sample_miss[i]) begin
        if (!any_valid || sample_val[i] < low_val) low_val = sample_val[i];
        if (!any_valid || sample_val[i] > high_val) high_val = sample_val[i];
        any_valid = 1'b1;
      end
    end
    foreach (bin_counts[i]) bin_counts[i] = 0;
    for (int i = 0; i < num_loaded; i++) begin
      if (!sample_miss[i]) begin
        b = scaled_bin(sample_val[i]);
        if (bin_counts[b] < 8191) bin_counts[b]++;
      end
    end
    peak_val = 0;
    foreach (bin_counts[i]) if (bin_counts[i] > peak_val) peak_val = bin_counts[i];
    num_loaded = 0;
  endtask

  task automatic predict_word(logic [1:0] cmd, logic signed [31:0] v, bit miss, bit last,
                              logic [7:0] idx);
    hist_result_t r;
    r.count = '0;
    r.fraction = '0;
    r.dbyte = '0;
    case (cmd)
      arh_pkg::CMD_LOAD: begin
        if (num_loaded < arh_pkg::MaxSamples) begin
          sample_val[num_loaded] = v;
          sample_miss[num_loaded] = miss;
          num_loaded++;
        end
        if (!last) return;
        build_histogram();
        r.kind = arh_pkg::KIND_BUILT;
      end
      arh_pkg::CMD_READ: begin
        r.kind = arh_pkg::KIND_READ;
        r.count = 13'(bin_counts[idx]);
        if (peak_val != 0) r.fraction = 16'((longint'(bin_counts[idx]) * 32768) / peak_val);
      end
      arh_pkg::CMD_MAP: begin
        r.kind = arh_pkg::KIND_MAP;
        r.dbyte = miss ? 8'd0 : 8'(scaled_bin(v));
      end
      default: return;
    endcase
    r.peak = 13'(peak_val);
    r.rmin = 32'(low_val);
    r.rmax = 32'(high_val);
    pending_results.insert(pending_results.size(), r);
  endtask

  // Sends one word after a random gap and predicts its result once accepted.
  task automatic send_word(logic [1:0] cmd, logic signed [31:0] v, bit miss, bit last,
                           logic [7:0] idx);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_cmd <= cmd;
    in_sample_value <= v;
    in_is_missing <= miss;
    in_is_last <= last;
    in_bin_index <= idx;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && !in_stall));
    predict_word(cmd, v, miss, last, idx);
    words_sent++;
  endtask

  task automatic load(logic signed [31:0] v, bit miss, bit last);
    send_word(arh_pkg::CMD_LOAD, v, miss, last, 8'($urandom));
  endtask

  task automatic read_bin(logic [7:0] idx);
    send_word(arh_pkg::CMD_READ, $urandom, 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), idx);
  endtask

  task automatic map_value(logic signed [31:0] v, bit miss);
    send_word(arh_pkg::CMD_MAP, v, miss, 1'($urandom_range(0, 1)), 8'($urandom));
  endtask

  task automatic test_after_reset();
    read_bin(8'd0);
    read_bin(8'd255);
    map_value(32'sd12345, 1'b0);
    map_value(32'sd12345, 1'b1);
    send_word(arh_pkg::CMD_NONE, $urandom, 1'b0, 1'b1, 8'($urandom));
  endtask

  task automatic test_directed_sets();
    // Full-scale range, then reads at the edges and the middle.
    load(32'h8000_0000, 1'b0, 1'b0);
    load(32'h7fff_ffff, 1'b0, 1'b0);
    load(32'sd0, 1'b0, 1'b0);
    load(32'sd5, 1'b1, 1'b1);
    read_bin(8'd0);
    read_bin(8'd1);
    read_bin(8'd128);
    read_bin(8'd255);
    // Narrow range with maps below, inside and above it.
    load(32'sd100, 1'b0, 1'b0);
    load(32'sd200, 1'b0, 1'b1);
    map_value(32'sd50, 1'b0);
    map_value(32'sd150, 1'b0);
    map_value(32'sd300, 1'b0);
    map_value(32'sd150, 1'b1);
    // Equal range sends everything to bin 1.
    load(-32'sd7, 1'b0, 1'b0);
    load(-32'sd7, 1'b0, 1'b1);
    map_value(-32'sd7, 1'b0);
    map_value(32'sd9, 1'b0);
    read_bin(8'd1);
    // A set with only missing samples leaves a zero range and zero peak.
    load(32'sd42, 1'b1, 1'b1);
    read_bin(8'd1);
    map_value(32'sd1, 1'b0);
  endtask

  task automatic test_random_sets();
    int set_len, span_kind;
    logic signed [31:0] base, span, v;
    while (words_sent < 1620) begin
      send_gap_max = ($urandom_range(0, 4) == 0) ? 0 : 12;
      set_len = $urandom_range(1, 16);
      span_kind = $urandom_range(0, 3);
      base = $urandom;
      span = (span_kind == 0) ? 0 : (span_kind == 1) ? $urandom_range(1, 1000) : $urandom;
      for (int i = 0; i < set_len; i++) begin
        v = (span_kind == 3) ? $urandom : base + ((span == 0) ? 0 : $urandom % span);
        load(v, ($urandom % 5) == 0, i == set_len - 1);
      end
      repeat ($urandom_range(2, 10)) begin
        case ($urandom_range(0, 5))
          0, 1, 2: read_bin(8'($urandom));
          3, 4:    map_value(($urandom_range(0, 1) != 0) ? base + $urandom_range(0, 2000) - 500
                             : $urandom, ($urandom % 6) == 0);
          default: send_word(arh_pkg::CMD_NONE, $urandom, 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), 8'($urandom));
        endcase
      end
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result checker: compares each accepted word with the oldest prediction.
  always @(posedge clk) begin
    hist_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      results_taken++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result kind %0d", $time, out_result_kind);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_result_kind !== e.kind) begin
          $display("%0t: kind exp %0d got %0d", $time, e.kind, out_result_kind); errors++;
        end
        if (out_bin_count !== e.count) begin
          $display("%0t: count exp %0d got %0d", $time, e.count, out_bin_count); errors++;
        end
        if (out_bin_fraction !== e.fraction) begin
          $display("%0t: fraction exp %0d got %0d", $time, e.fraction, out_bin_fraction);
          errors++;
        end
        if (out_display_byte !== e.dbyte) begin
          $display("%0t: byte exp %0d got %0d", $time, e.dbyte, out_display_byte); errors++;
        end
        if (out_peak_count !== e.peak) begin
          $display("%0t: peak exp %0d got %0d", $time, e.peak, out_peak_count); errors++;
        end
        if (out_range_min !== e.rmin) begin
          $display("%0t: min exp %0d got %0d", $time, e.rmin, out_range_min); errors++;
        end
        if (out_range_max !== e.rmax) begin
          $display("%0t: max exp %0d got %0d", $time, e.rmax, out_range_max); errors++;
        end
      end
    end
  end

  // Receiver stall: a fresh wait is drawn after every accepted result word.
  always @(negedge clk) begin
    if (results_seen != results_taken) begin
      results_seen = results_taken;
      stall_left = $urandom_range(0, stall_max);
    end
    out_stall <= (stall_left > 0);
    if (stall_left > 0) stall_left--;
  end

  initial begin
    foreach (bin_counts[i]) bin_counts[i] = 0;
    num_loaded = 0;
    low_val = 0;
    high_val = 0;
    peak_val = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_after_reset();
    test_directed_sets();
    test_random_sets();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/arh_pkg.sv
hdl/arh_div.sv
hdl/auto_range_histogram.sv
tb/tb_auto_range_histogram.sv
